[sv/rbst_pkg.sv]
// Shared constants, types and register codes for the four-wide ray/box slab test.
// No dependencies; every other file imports this package.
`default_nettype none

package rbst_pkg;

  localparam int LANES       = 4;
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int DIFF_W      = COORD_WIDTH + 1;        // exact coordinate difference
  localparam int PROD_W      = DIFF_W + COORD_WIDTH;   // exact product
  localparam int FAR_W       = 31;
  localparam int AXIS_W      = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [LANES-1:0]              lane_mask_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // Axis codes; the fourth code means nothing and the word is dropped.
  typedef enum logic [AXIS_W-1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Z  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_INV_DIR_X = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_INV_DIR_Y = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_INV_DIR_Z = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_FAR_LIMIT = 3'd6;

  // Accumulate-stage control shared by all lanes.
  typedef struct packed {
    logic en;       // a valid slice sits in the accumulate stage
    logic restart;  // that slice is axis x: reload entry/exit first
  } acc_ctl_t;

  // Control into the merge/result stage.
  typedef struct packed {
    logic reserve;  // axis z word accepted: claim one result slot
    logic emit;     // lane state holds a finished node: push the mask
  } merge_ctl_t;

endpackage

`default_nettype wire

[sv/rbst_if.sv]
// Valid/ready channel interfaces: one axis slice of a node in, one miss mask out.
// Depends on rbst_pkg.
`default_nettype none

interface rbst_slice_if;
  import rbst_pkg::*;

  logic                valid;
  logic                ready;
  logic [AXIS_W-1:0]   axis;
  coord_t              min_lane0;
  coord_t              min_lane1;
  coord_t              min_lane2;
  coord_t              min_lane3;
  coord_t              max_lane0;
  coord_t              max_lane1;
  coord_t              max_lane2;
  coord_t              max_lane3;

  modport source (
    output valid, axis, min_lane0, min_lane1, min_lane2, min_lane3,
           max_lane0, max_lane1, max_lane2, max_lane3,
    input  ready
  );
  modport sink (
    input  valid, axis, min_lane0, min_lane1, min_lane2, min_lane3,
           max_lane0, max_lane1, max_lane2, max_lane3,
    output ready
  );
endinterface

interface rbst_result_if;
  import rbst_pkg::*;

  logic       valid;
  logic       ready;
  lane_mask_t miss_mask;

  modport source (output valid, miss_mask, input ready);
  modport sink   (input valid, miss_mask, output ready);
endinterface

`default_nettype wire

[sv/rbst_lane.sv]
// One slab-test lane: subtract, multiply, scale/saturate/order, accumulate.
// Depends on rbst_pkg.
`default_nettype none

module rbst_lane
  import rbst_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rbst_pkg::coord_t  min_val,
  input  wire rbst_pkg::coord_t  max_val,
  input  wire rbst_pkg::coord_t  org,      // origin for the slice entering now
  input  wire rbst_pkg::coord_t  inv,      // inverse direction for the multiply stage
  input  wire rbst_pkg::coord_t  lim,      // exit distance on restart
  input  wire rbst_pkg::acc_ctl_t ctl,
  output logic                   miss
);

  // floor(p / 2^FRAC_BITS) clamped to the coordinate range
  function automatic coord_t scale_sat(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-FRAC_BITS-COORD_WIDTH:0] top;
    top = p[PROD_W-1:FRAC_BITS+COORD_WIDTH-1];
    if ((&top) || !(|top)) begin
      return p[FRAC_BITS +: COORD_WIDTH];
    end else if (p[PROD_W-1]) begin
      return COORD_MIN;
    end else begin
      return COORD_MAX;
    end
  endfunction

  logic signed [DIFF_W-1:0] diff_lo, diff_hi;
  logic signed [PROD_W-1:0] prod_lo, prod_hi;
  coord_t                   t_near, t_far;
  coord_t                   entry_dist, exit_dist;
  coord_t                   scl_lo, scl_hi;
  coord_t                   base_entry, base_exit;

  // difference and product stages run free; validity rides in the top level
  always_ff @(posedge clk) begin
    diff_lo <= {min_val[COORD_WIDTH-1], min_val} - {org[COORD_WIDTH-1], org};
    diff_hi <= {max_val[COORD_WIDTH-1], max_val} - {org[COORD_WIDTH-1], org};
    prod_lo <= diff_lo * inv;
    prod_hi <= diff_hi * inv;
  end

  always_comb begin
    scl_lo = scale_sat(prod_lo);
    scl_hi = scale_sat(prod_hi);
  end

  always_ff @(posedge clk) begin
    if (scl_lo > scl_hi) begin
      t_near <= scl_hi;
      t_far  <= scl_lo;
    end else begin
      t_near <= scl_lo;
      t_far  <= scl_hi;
    end
  end

  always_comb begin
    base_entry = ctl.restart ? '0  : entry_dist;
    base_exit  = ctl.restart ? lim : exit_dist;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_dist <= '0;
      exit_dist  <= '0;
    end else if (ctl.en) begin
      entry_dist <= (t_near > base_entry) ? t_near : base_entry;
      exit_dist  <= (t_far  < base_exit)  ? t_far  : base_exit;
    end
  end

  // entry only grows and exit only shrinks between restarts, so the
  // current compare equals the sticky miss of every slice since restart
  assign miss = entry_dist > exit_dist;

endmodule

`default_nettype wire

[sv/rbst_merge.sv]
// Merge stage: gathers lane miss bits into a mask and queues it for the receiver.
// Depends on rbst_pkg and rbst_result_if.
`default_nettype none

module rbst_merge
  import rbst_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rbst_pkg::lane_mask_t lane_miss,
  input  wire rbst_pkg::merge_ctl_t ctl,
  output logic                      slot_free,
  rbst_result_if.source             result
);

  lane_mask_t          queue_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   fill;
  logic [QCNT_W-1:0]   pending;   // results claimed but not yet taken
  logic                pop;

  assign pop              = result.valid && result.ready;
  assign result.valid     = (fill != '0);
  assign result.miss_mask = queue_mem[rd_ptr];
  assign slot_free        = (pending != QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      queue_mem[wr_ptr] <= lane_miss;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      fill    <= '0;
      pending <= '0;
    end else begin
      if (ctl.emit) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({ctl.emit, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
      case ({ctl.reserve, pop})
        2'b10:   pending <= pending + 1'b1;
        2'b01:   pending <= pending - 1'b1;
        default: pending <= pending;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/ray_box4_slab_test_top.sv]
// Top level of the four-wide ray/box slab test: configuration registers,
// slice pipeline control, four lanes and the merge stage.
// Depends on rbst_pkg, rbst_if, rbst_lane and rbst_merge.
//
// Usage:
//  - cfg_we/cfg_index/cfg_data write the ray: origin x/y/z, inverse
//    direction x/y/z, far limit (indexes 0..6). Write only while idle.
//  - slice: one word per axis of a node, x first (restarts the lanes),
//    then y, then z. Each word carries four box minima and maxima.
//    A word with the unused axis code is taken and dropped.
//  - result: one 4-bit miss mask per z word, bit i = ray misses child i.
//  - Throughput: one slice word per cycle while slice.ready is high.
//  - Pipeline: a z word accepted on slice passes subtract, multiply,
//    scale/order, accumulate and a queue write before its mask is on result.
//  - Stall: masks wait in an 8-entry queue; slice.ready drops only when
//    eight z words are claimed and not yet taken, so the input keeps
//    flowing while the receiver holds off for a while.
//  - Reset (rst, synchronous) clears registers, lane distances and queue.
`default_nettype none

module ray_box4_slab_test_top
  import rbst_pkg::*;
(
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [rbst_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [rbst_pkg::CFG_DATA_W-1:0]    cfg_data,
  rbst_slice_if.sink                              slice,
  rbst_result_if.source                           result
);

  // ray registers
  coord_t             origin_x, origin_y, origin_z;
  coord_t             inv_dir_x, inv_dir_y, inv_dir_z;
  logic [FAR_W-1:0]   far_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x  <= '0;
      origin_y  <= '0;
      origin_z  <= '0;
      inv_dir_x <= '0;
      inv_dir_y <= '0;
      inv_dir_z <= '0;
      far_limit <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X:  origin_x  <= cfg_data[COORD_WIDTH-1:0];
        REG_ORIGIN_Y:  origin_y  <= cfg_data[COORD_WIDTH-1:0];
        REG_ORIGIN_Z:  origin_z  <= cfg_data[COORD_WIDTH-1:0];
        REG_INV_DIR_X: inv_dir_x <= cfg_data[COORD_WIDTH-1:0];
        REG_INV_DIR_Y: inv_dir_y <= cfg_data[COORD_WIDTH-1:0];
        REG_INV_DIR_Z: inv_dir_z <= cfg_data[COORD_WIDTH-1:0];
        REG_FAR_LIMIT: far_limit <= cfg_data[FAR_W-1:0];
        default:       ;
      endcase
    end
  end

  // far limit always fits a positive coordinate at this width
  coord_t lim;
  assign lim = COORD_WIDTH'({1'b0, far_limit});

  // input handshake
  logic       slot_free;
  logic       in_acc;
  logic       in_used;
  assign slice.ready = slot_free;
  assign in_acc      = slice.valid && slice.ready;
  assign in_used     = in_acc && (slice.axis == AXIS_X || slice.axis == AXIS_Y ||
                                  slice.axis == AXIS_Z);

  // origin for the difference stage, picked by the incoming axis
  coord_t org;
  always_comb begin
    case (slice.axis)
      AXIS_X:  org = origin_x;
      AXIS_Y:  org = origin_y;
      AXIS_Z:  org = origin_z;
      default: org = '0;
    endcase
  end

  // slice control down the pipe: diff -> product -> order -> accumulate
  logic              v_diff, v_prod, v_ord, emit;
  logic [AXIS_W-1:0] ax_diff, ax_prod, ax_ord;

  always_ff @(posedge clk) begin
    ax_diff <= slice.axis;
    ax_prod <= ax_diff;
    ax_ord  <= ax_prod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_diff <= 1'b0;
      v_prod <= 1'b0;
      v_ord  <= 1'b0;
      emit   <= 1'b0;
    end else begin
      v_diff <= in_used;
      v_prod <= v_diff;
      v_ord  <= v_prod;
      emit   <= v_ord && (ax_ord == AXIS_Z);   // lanes now hold the full node
    end
  end

  // inverse direction for the multiply stage, by that stage's axis
  coord_t inv;
  always_comb begin
    case (ax_diff)
      AXIS_X:  inv = inv_dir_x;
      AXIS_Y:  inv = inv_dir_y;
      AXIS_Z:  inv = inv_dir_z;
      default: inv = '0;
    endcase
  end

  acc_ctl_t acc_ctl;
  assign acc_ctl.en      = v_ord;
  assign acc_ctl.restart = (ax_ord == AXIS_X);

  coord_t min_v [LANES];
  coord_t max_v [LANES];
  assign min_v[0] = slice.min_lane0;
  assign min_v[1] = slice.min_lane1;
  assign min_v[2] = slice.min_lane2;
  assign min_v[3] = slice.min_lane3;
  assign max_v[0] = slice.max_lane0;
  assign max_v[1] = slice.max_lane1;
  assign max_v[2] = slice.max_lane2;
  assign max_v[3] = slice.max_lane3;

  lane_mask_t lane_miss;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    rbst_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .min_val (min_v[g]),
      .max_val (max_v[g]),
      .org     (org),
      .inv     (inv),
      .lim     (lim),
      .ctl     (acc_ctl),
      .miss    (lane_miss[g])
    );
  end

  merge_ctl_t merge_ctl;
  assign merge_ctl.reserve = in_acc && (slice.axis == AXIS_Z);
  assign merge_ctl.emit    = emit;

  rbst_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .lane_miss (lane_miss),
    .ctl       (merge_ctl),
    .slot_free (slot_free),
    .result    (result)
  );

endmodule

`default_nettype wire

[test/ray_box4_slab_test_top_test.sv]
// Self-checking bench for the four-wide ray/box slab test: directed words, then random nodes.
// Predicts miss masks from its own slab model; needs rbst_pkg, rbst_if and the top level.
`default_nettype none

module ray_box4_slab_test_top_test;
  import rbst_pkg::*;

  // Unused axis code: the block takes the word and drops it.
  localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;
  // Extra wait after the last mask: slack for x/y words still in flight.
  localparam int DRAIN_TAIL  = 12;
  // Run limit: the bench reports a failure if the run reaches this cycle count.
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 240;
  localparam int HOLD_PHASE  = 4;
  localparam int HOLD_CYCLES = 300;

  typedef coord_t [LANES-1:0] lanes_t;

  // One row of the directed table: a register write or a slice word.
  typedef struct {
    bit                     is_cfg;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  data;
    logic [AXIS_W-1:0]      ax;
    lanes_t                 lo;
    lanes_t                 hi;
    bit                     typed;  // mask below is the expected one
    lane_mask_t             mask;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  rbst_slice_if  slice_bus ();
  rbst_result_if mask_bus ();

  ray_box4_slab_test_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .slice     (slice_bus),
    .result    (mask_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Ray registers and lane distances as the block should hold them.
  coord_t            ray_org    [3];
  coord_t            ray_inv    [3];
  logic [FAR_W-1:0]  ray_far;
  coord_t            entry_d    [LANES];
  coord_t            exit_d     [LANES];
  lane_mask_t        miss_acc;

  lane_mask_t        mask_expected [$];
  dir_row_t          dir_rows [$];

  int fails     = 0;
  int cycle_cnt = 0;
  int idle_mode = 0;   // 0 none, 1 sender, 2 receiver, 3 both
  int phase_no  = -1;

  initial begin
    for (int i = 0; i < 3; i++) begin
      ray_org[i] = '0;
      ray_inv[i] = '0;
    end
    ray_far  = '0;
    miss_acc = '0;
    for (int i = 0; i < LANES; i++) begin
      entry_d[i] = '0;
      exit_d[i]  = '0;
    end
  end

  function automatic void add_row(dir_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // Distance along the ray to one slab plane: exact difference and product,
  // floor shift to Q16.16, then clamp to the coordinate range.
  function automatic coord_t slab_dist(coord_t bound, coord_t org, coord_t inv);
    logic signed [COORD_WIDTH:0]     diff;
    logic signed [2*COORD_WIDTH+1:0] prod;
    diff = {bound[COORD_WIDTH-1], bound} - {org[COORD_WIDTH-1], org};
    prod = diff * inv;
    prod = prod >>> FRAC_BITS;
    if (prod[2*COORD_WIDTH+1:COORD_WIDTH-1] == '0 ||
        prod[2*COORD_WIDTH+1:COORD_WIDTH-1] == '1)
      return prod[COORD_WIDTH-1:0];
    return prod[2*COORD_WIDTH+1] ? COORD_MIN : COORD_MAX;
  endfunction

  // Fold one axis word into the lane state; z words yield the miss mask.
  task automatic slab_step(input logic [AXIS_W-1:0] ax, input lanes_t lo, input lanes_t hi,
                           output bit emit, output lane_mask_t mask);
    coord_t org, inv, tn, tf, t;
    emit = 1'b0;
    mask = miss_acc;
    if (ax == AXIS_NONE)
      return;
    org = ray_org[ax];
    inv = ray_inv[ax];
    if (ax == AXIS_X) begin
      for (int i = 0; i < LANES; i++) begin
        entry_d[i] = '0;
        exit_d[i]  = {1'b0, ray_far};
      end
      miss_acc = '0;
    end
    for (int i = 0; i < LANES; i++) begin
      tn = slab_dist(lo[i], org, inv);
      tf = slab_dist(hi[i], org, inv);
      if (tn > tf) begin
        t  = tn;
        tn = tf;
        tf = t;
      end
      if (tn > entry_d[i])
        entry_d[i] = tn;
      if (tf < exit_d[i])
        exit_d[i] = tf;
      if (entry_d[i] > exit_d[i])
        miss_acc[i] = 1'b1;
    end
    emit = (ax == AXIS_Z);
    mask = miss_acc;
  endtask

  function automatic lanes_t lanes(coord_t l0, coord_t l1, coord_t l2, coord_t l3);
    return {l3, l2, l1, l0};
  endfunction

  // Whole units to Q16.16.
  function automatic coord_t fx(int n);
    return coord_t'(n) <<< FRAC_BITS;
  endfunction

  function automatic dir_row_t word_row(logic [AXIS_W-1:0] ax, lanes_t lo, lanes_t hi,
                                        bit typed = 1'b0, lane_mask_t mask = '0);
    dir_row_t r;
    r = '{default: '0};
    r.ax    = ax;
    r.lo    = lo;
    r.hi    = hi;
    r.typed = typed;
    r.mask  = mask;
    return r;
  endfunction

  function automatic dir_row_t reg_row(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    dir_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  // Coordinates within +-64.0 so that boxes sit around the ray.
  function automatic coord_t near_coord();
    return coord_t'($urandom_range(32'h0080_0000)) - 32'sh0040_0000;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rnd_reg(int idx);
    int pick;
    pick = $urandom_range(7);
    if (idx == REG_FAR_LIMIT) begin
      case (pick)
        0: return $urandom;          // top data bit is dropped by the register
        1: return '0;
        2: return 32'h7FFF_FFFF;
        default: return $urandom_range(32'h0080_0000);
      endcase
    end
    if (idx >= REG_INV_DIR_X) begin
      case (pick)
        0: return '0;
        1: return COORD_MAX;
        2: return COORD_MIN;
        3: return $urandom;
        default: return $urandom_range(32'h0008_0000) - 32'h0004_0000;  // +-4.0
      endcase
    end
    return (pick == 0) ? $urandom : near_coord();
  endfunction

  // Mostly small boxes near the origin, some swapped, some fully random.
  task automatic rnd_boxes(output lanes_t lo, output lanes_t hi);
    coord_t c, t;
    for (int i = 0; i < LANES; i++) begin
      if ($urandom_range(7) == 0) begin
        lo[i] = coord_t'($urandom);
        hi[i] = coord_t'($urandom);
      end else begin
        c     = near_coord();
        lo[i] = c;
        hi[i] = c + coord_t'($urandom_range(32'h0010_0000));
        if ($urandom_range(7) == 0) begin
          t     = lo[i];
          lo[i] = hi[i];
          hi[i] = t;
        end
      end
    end
  endtask

  function automatic bit sender_rests();
    case (idle_mode)
      1: return $urandom_range(99) < 49;
      3: return $urandom_range(99) < 16;
      default: return 1'b0;
    endcase
  endfunction

  // Offer one word; prediction is made at the edge that takes it.
  task automatic send_word(input logic [AXIS_W-1:0] ax, input lanes_t lo, input lanes_t hi,
                           input bit typed, input lane_mask_t typed_mask);
    bit         emit;
    lane_mask_t mask;
    @(negedge clk);
    while (sender_rests()) begin
      slice_bus.valid <= 1'b0;
      @(posedge clk);
      @(negedge clk);
    end
    slice_bus.valid     <= 1'b1;
    slice_bus.axis      <= ax;
    slice_bus.min_lane0 <= lo[0];
    slice_bus.min_lane1 <= lo[1];
    slice_bus.min_lane2 <= lo[2];
    slice_bus.min_lane3 <= lo[3];
    slice_bus.max_lane0 <= hi[0];
    slice_bus.max_lane1 <= hi[1];
    slice_bus.max_lane2 <= hi[2];
    slice_bus.max_lane3 <= hi[3];
    do @(posedge clk); while (!slice_bus.ready);
    slab_step(ax, lo, hi, emit, mask);
    if (emit)
      mask_expected.insert(mask_expected.size(), typed ? typed_mask : mask);
  endtask

  // Stop offering, wait for every pending mask, then let x/y words clear the pipe.
  task automatic wait_drain();
    @(negedge clk);
    slice_bus.valid <= 1'b0;
    while (mask_expected.size() != 0)
      @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z:    ray_org[idx - REG_ORIGIN_X]  = data;
      REG_INV_DIR_X, REG_INV_DIR_Y, REG_INV_DIR_Z: ray_inv[idx - REG_INV_DIR_X] = data;
      REG_FAR_LIMIT:                               ray_far = data[FAR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver: random stalls per phase, plus one long hold-off so the mask
  // queue fills and the block backs up its slice input.
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    mask_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && phase_no == HOLD_PHASE) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        mask_bus.ready <= 1'b0;
      end else if (idle_mode == 2) begin
        mask_bus.ready <= $urandom_range(99) >= 49;
      end else if (idle_mode == 3) begin
        mask_bus.ready <= $urandom_range(99) >= 16;
      end else begin
        mask_bus.ready <= 1'b1;
      end
    end
  end

  // Checker: every mask taken is matched against the oldest prediction.
  always @(posedge clk) begin : mask_check
    lane_mask_t want;
    if (!rst && mask_bus.valid && mask_bus.ready) begin
      if (mask_expected.size() == 0) begin
        if (fails < 10)
          $display("unexpected miss mask %b at cycle %0d", mask_bus.miss_mask, cycle_cnt);
        fails++;
      end else begin
        want = mask_expected.pop_front();
        if (mask_bus.miss_mask !== want) begin
          if (fails < 10)
            $display("miss mask mismatch at cycle %0d: expected %b, got %b",
                     cycle_cnt, want, mask_bus.miss_mask);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout: %0d masks still pending", mask_expected.size());
      $display("** ray_box4_slab_test_top: FAILED **");
      $finish;
    end
  end

  // Sender: reset, directed table, then random phases.
  initial begin
    lanes_t   lo, hi;
    dir_row_t row;
    int       n, pick, last_ax;
    bit       paused;

    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    slice_bus.valid     = 1'b0;
    slice_bus.axis      = AXIS_X;
    slice_bus.min_lane0 = '0;
    slice_bus.min_lane1 = '0;
    slice_bus.min_lane2 = '0;
    slice_bus.min_lane3 = '0;
    slice_bus.max_lane0 = '0;
    slice_bus.max_lane1 = '0;
    slice_bus.max_lane2 = '0;
    slice_bus.max_lane3 = '0;

    // After reset every inverse direction is zero: all distances are 0 and
    // entry == exit, so nothing misses. First a z word with no x before it.
    add_row(word_row(AXIS_Z, '0, '0, 1'b1, 4'b0000));
    add_row(word_row(AXIS_NONE, lanes(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN),
                     lanes(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX)));
    add_row(word_row(AXIS_X, lanes(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX),
                     lanes(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN)));
    add_row(word_row(AXIS_Y, lanes(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN),
                     lanes(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX)));
    add_row(word_row(AXIS_Z, lanes(fx(3), fx(-3), COORD_MAX, COORD_MIN),
                     lanes(fx(-3), fx(3), COORD_MIN, COORD_MAX), 1'b1, 4'b0000));
    // Unit ray from the origin, far limit 100: distances equal coordinates.
    add_row(reg_row(REG_ORIGIN_X, '0));
    add_row(reg_row(REG_ORIGIN_Y, '0));
    add_row(reg_row(REG_ORIGIN_Z, '0));
    add_row(reg_row(REG_INV_DIR_X, fx(1)));
    add_row(reg_row(REG_INV_DIR_Y, fx(1)));
    add_row(reg_row(REG_INV_DIR_Z, fx(1)));
    add_row(reg_row(REG_FAR_LIMIT, fx(100)));
    // lane 0 hit, lane 1 past the far limit, lane 2 behind the origin,
    // lane 3 with min and max swapped (still a hit)
    for (int a = AXIS_X; a <= AXIS_Z; a++)
      add_row(word_row(AXIS_W'(a), lanes(fx(1), fx(200), fx(-5), fx(2)),
                       lanes(fx(2), fx(300), fx(-1), fx(1)),
                       a == AXIS_Z, 4'b0110));
    // Slabs that just touch: entry == exit on lane 0 must not miss.
    add_row(word_row(AXIS_X, lanes(fx(3), fx(-2), fx(50), fx(0)),
                     lanes(fx(5), fx(4), fx(60), fx(100))));
    add_row(word_row(AXIS_Y, lanes(fx(5), fx(1), fx(10), fx(-3)),
                     lanes(fx(7), fx(3), fx(20), fx(-2))));
    add_row(word_row(AXIS_Z, lanes(fx(0), fx(2), fx(-9), fx(1)),
                     lanes(fx(9), fx(6), fx(9), fx(2))));
    // y and z with no x: they fold onto whatever the lanes hold
    add_row(word_row(AXIS_Y, lanes(fx(-1), fx(8), fx(0), fx(4)),
                     lanes(fx(6), fx(9), fx(1), fx(5))));
    add_row(word_row(AXIS_Z, lanes(fx(4), fx(0), fx(-4), fx(0)),
                     lanes(fx(5), fx(1), fx(4), fx(0))));
    // Extreme ray: full-scale inverse directions and origins, widest far limit;
    // distances saturate both ways.
    add_row(reg_row(REG_ORIGIN_X, COORD_MIN));
    add_row(reg_row(REG_ORIGIN_Y, COORD_MAX));
    add_row(reg_row(REG_ORIGIN_Z, fx(7)));
    add_row(reg_row(REG_INV_DIR_X, COORD_MAX));
    add_row(reg_row(REG_INV_DIR_Y, COORD_MIN));
    add_row(reg_row(REG_INV_DIR_Z, fx(-1)));
    add_row(reg_row(REG_FAR_LIMIT, 32'h7FFF_FFFF));
    add_row(word_row(AXIS_X, lanes(COORD_MAX, COORD_MIN, '0, fx(1)),
                     lanes(COORD_MIN, COORD_MAX, fx(-1), '0)));
    add_row(word_row(AXIS_Y, lanes(COORD_MIN, COORD_MIN, COORD_MAX, fx(-7)),
                     lanes(COORD_MAX, fx(1), COORD_MAX, fx(7))));
    add_row(word_row(AXIS_Z, lanes(fx(7), COORD_MIN, fx(8), fx(6)),
                     lanes(fx(7), COORD_MAX, fx(-8), fx(9))));
    // Zero far limit: only lanes whose slabs straddle distance 0 survive.
    add_row(reg_row(REG_FAR_LIMIT, '0));
    add_row(word_row(AXIS_X, lanes(COORD_MIN, fx(-2), fx(0), fx(1)),
                     lanes(COORD_MIN + 1, fx(2), fx(0), fx(3))));
    add_row(word_row(AXIS_Y, lanes(fx(-1), COORD_MAX, fx(0), fx(1)),
                     lanes(COORD_MAX, fx(0), fx(0), fx(2))));
    add_row(word_row(AXIS_Z, lanes(fx(6), fx(8), fx(7), fx(-6)),
                     lanes(fx(8), fx(6), fx(7), fx(-8))));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      row = dir_rows[r];
      if (row.is_cfg) begin
        wait_drain();
        cfg_write(row.idx, row.data);
      end else begin
        send_word(row.ax, row.lo, row.hi, row.typed, row.mask);
      end
    end

    // Random phases: fresh ray each phase, idling pattern cycles through
    // none / sender / receiver / both. Mostly whole x-y-z nodes, with
    // dropped words, broken nodes and stray y/z words mixed in.
    for (int p = 0; p < PHASES; p++) begin
      wait_drain();
      idle_mode = p % 4;
      phase_no  = p;
      for (int r = REG_ORIGIN_X; r <= REG_FAR_LIMIT; r++)
        cfg_write(CFG_INDEX_W'(r), rnd_reg(r));
      n      = 0;
      paused = 1'b0;
      while (n < PHASE_WORDS) begin
        pick = $urandom_range(99);
        if (pick < 80) begin
          for (int a = AXIS_X; a <= AXIS_Z; a++) begin
            rnd_boxes(lo, hi);
            send_word(AXIS_W'(a), lo, hi, 1'b0, '0);
          end
          n += 3;
        end else if (pick < 88) begin
          rnd_boxes(lo, hi);
          send_word(AXIS_NONE, lo, hi, 1'b0, '0);
        end else if (pick < 94) begin
          // node cut short after x, or after x and y
          last_ax = $urandom_range(1);
          for (int a = AXIS_X; a <= last_ax; a++) begin
            rnd_boxes(lo, hi);
            send_word(AXIS_W'(a), lo, hi, 1'b0, '0);
            n++;
          end
        end else begin
          rnd_boxes(lo, hi);
          send_word($urandom_range(1) ? AXIS_Y : AXIS_Z, lo, hi, 1'b0, '0);
          n++;
        end
        // once in odd phases the sender pauses until every mask is back
        if (p % 2 == 1 && n >= PHASE_WORDS / 2 && !paused) begin
          paused = 1'b1;
          wait_drain();
        end
      end
    end

    wait_drain();
    if (fails == 0)
      $display("** ray_box4_slab_test_top: PASSED **");
    else
      $display("** ray_box4_slab_test_top: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
sv/rbst_pkg.sv
sv/rbst_if.sv
sv/rbst_lane.sv
sv/rbst_merge.sv
sv/ray_box4_slab_test_top.sv
test/ray_box4_slab_test_top_test.sv
